@@ sv/nvic_pkg.sv @@
// Shared types, register map codes and helpers of the interrupt collector.
// No dependencies.
`default_nettype none
package nvic_pkg;

	// item operations
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LINE  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// alias selector in offset bits 3:2
	typedef enum logic [1:0] {
		AOP_PLAIN = 2'd0,
		AOP_SET   = 2'd1,
		AOP_CLR   = 2'd2,
		AOP_TOG   = 2'd3
	} aop_t;

	// selection machine phase
	typedef enum logic [5:0] {
		PH_IDLE    = 6'h00,
		PH_DELAY1  = 6'h01,
		PH_DELAY2  = 6'h02,
		PH_PENDING = 6'h04,
		PH_SERVICE = 6'h20
	} phase_t;

	// controller states
	typedef enum logic [1:0] {
		C_IDLE = 2'd0,
		C_EXEC = 2'd1,
		C_UPD  = 2'd2,
		C_FIN  = 2'd3
	} cstate_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic update;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// register bases, offset bits 12:4
	localparam logic [8:0] R_VECTOR   = 9'h00;
	localparam logic [8:0] R_LEVELACK = 9'h01;
	localparam logic [8:0] R_CTRL     = 9'h02;
	localparam logic [8:0] R_STAT     = 9'h03;
	localparam logic [8:0] R_RAW0     = 9'h04;
	localparam logic [8:0] R_RAW1     = 9'h05;
	localparam logic [8:0] R_PRIO0    = 9'h06;
	localparam logic [8:0] R_PRIO15   = 9'h15;
	localparam logic [8:0] R_VBASE    = 9'h16;
	localparam logic [8:0] R_DEBUG    = 9'h17;
	localparam logic [8:0] R_DBGRD0   = 9'h18;
	localparam logic [8:0] R_DBGRD1   = 9'h19;
	localparam logic [8:0] R_DFLAG    = 9'h1A;
	localparam logic [8:0] R_DREQ0    = 9'h1B;
	localparam logic [8:0] R_DREQ1    = 9'h1C;
	localparam logic [8:0] R_VERSION  = 9'h1D;

	localparam logic [31:0] CW_RW_MASK  = 32'hC0FF00FF;
	localparam logic [31:0] PRI_RW_MASK = 32'h0F0F0F0F;
	localparam logic [31:0] VB_RW_MASK  = 32'hFFFFFFFC;
	localparam logic [31:0] VERSION_VAL = 32'h02000000;
	localparam logic [31:0] DBGRD0_VAL  = 32'hECA94567;
	localparam logic [31:0] DBGRD1_VAL  = 32'h1356DA98;
	localparam logic [31:0] CW_RESET    = 32'hC0030000;
	localparam logic [5:0]  STAT_MASK   = 6'h3F;
	localparam logic [15:0] DFLAG_MASK  = 16'hFFFF;

	// control word bits
	localparam int CW_SFTRST    = 31;
	localparam int CW_GATE      = 30;
	localparam int CW_BYPASS    = 20;
	localparam int CW_NONEST    = 19;
	localparam int CW_RSE       = 18;
	localparam int CW_FIQ_FINAL = 17;
	localparam int CW_IRQ_FINAL = 16;

	function automatic logic [31:0] apply_op(input logic [31:0] old, input logic [31:0] v,
		input aop_t op);
		logic [31:0] r;
		case (op)
			AOP_SET: r = old | v;
			AOP_CLR: r = old & ~v;
			AOP_TOG: r = old ^ v;
			default: r = v;
		endcase
		return r;
	endfunction

	// {found, index} of the highest set bit, halving tree
	function automatic logic [6:0] top_bit(input logic [63:0] m);
		logic [5:0]  idx;
		logic [31:0] w32;
		logic [15:0] w16;
		logic [7:0]  w8;
		logic [3:0]  w4;
		logic [1:0]  w2;
		idx = '0;
		if (|m[63:32]) begin idx[5] = 1'b1; w32 = m[63:32]; end else w32 = m[31:0];
		if (|w32[31:16]) begin idx[4] = 1'b1; w16 = w32[31:16]; end else w16 = w32[15:0];
		if (|w16[15:8]) begin idx[3] = 1'b1; w8 = w16[15:8]; end else w8 = w16[7:0];
		if (|w8[7:4]) begin idx[2] = 1'b1; w4 = w8[7:4]; end else w4 = w8[3:0];
		if (|w4[3:2]) begin idx[1] = 1'b1; w2 = w4[3:2]; end else w2 = w4[1:0];
		idx[0] = w2[1];
		return {|m, idx};
	endfunction

endpackage
`default_nettype wire

@@ sv/nvic_ctrl.sv @@
// Sequencing controller: capture, execute, select update, result load.
// Depends on nvic_pkg.
`default_nettype none
module nvic_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  nvic_pkg::status_t sts,
	output nvic_pkg::cmd_t   cmd
);

	nvic_pkg::cstate_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= nvic_pkg::C_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			nvic_pkg::C_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = nvic_pkg::C_EXEC;
				end
			end
			nvic_pkg::C_EXEC: begin
				cmd.exec = 1'b1;
				state_d = nvic_pkg::C_UPD;
			end
			nvic_pkg::C_UPD: begin
				cmd.update = 1'b1;
				state_d = nvic_pkg::C_FIN;
			end
			nvic_pkg::C_FIN: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d = nvic_pkg::C_IDLE;
				end
			end
			default: state_d = nvic_pkg::C_IDLE;
		endcase
	end

endmodule
`default_nettype wire

@@ sv/nvic_dp.sv @@
// Datapath: register file, source settings, priority select, output register.
// Depends on nvic_pkg.
`default_nettype none
module nvic_dp #(
	parameter int NUM_SOURCES      = 64,
	parameter int SOFT_RESET_TICKS = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  nvic_pkg::cmd_t   cmd,
	output nvic_pkg::status_t sts,
	input  wire [1:0]        operation,
	input  wire [12:0]       reg_offset,
	input  wire [31:0]       write_data,
	input  wire [5:0]        source_number,
	input  wire              source_level,
	output logic             out_valid,
	input  wire              out_stall,
	output logic [31:0]      read_data,
	output logic             irq_request,
	output logic             fiq_request,
	output logic             busy_res
);

	localparam logic [63:0] SRC_MASK = (NUM_SOURCES >= 64) ? {64{1'b1}} :
		((64'd1 << NUM_SOURCES) - 64'd1);

	// captured item
	nvic_pkg::op_t op_q;
	logic [12:0] off_q;
	logic [31:0] wd_q;
	logic [5:0]  src_q;
	logic        lvl_q;

	// block state
	logic [31:0] cw_q, vbase_q;
	logic [3:0]  settings_q [64];
	logic [63:0] raw_q, held_q;
	logic [6:0]  owner_q [4];
	logic [5:0]  cur_q, chosen_q, saved_q;
	logic        waiting_q;
	nvic_pkg::phase_t phase_q;
	logic [15:0] dflag_q;
	logic [2:0]  cnt_q;
	logic        upd_q;
	logic [31:0] rd_q;
	logic        out_valid_q;

	// decoded item
	logic [8:0] base;
	nvic_pkg::aop_t aop;
	logic is_prio, src_ok, tick_fire;
	assign base = off_q[12:4];
	assign aop = nvic_pkg::aop_t'(off_q[3:2]);
	assign is_prio = (base >= nvic_pkg::R_PRIO0) && (base <= nvic_pkg::R_PRIO15);
	assign src_ok = ({1'b0, src_q} < 7'(NUM_SOURCES));
	assign tick_fire = (op_q == nvic_pkg::OP_TICK) && (cnt_q == 3'd1);

	// per-source masks
	logic [63:0] en_m, trig_m, live, fiq_m;
	logic [63:0] lvl_m [4];
	always_comb begin
		for (int i = 0; i < 64; i++) begin
			en_m[i] = settings_q[i][2] & SRC_MASK[i];
			trig_m[i] = settings_q[i][3];
			for (int l = 0; l < 4; l++)
				lvl_m[l][i] = (settings_q[i][1:0] == 2'(l));
		end
	end
	assign live = (raw_q | trig_m) & SRC_MASK;
	assign fiq_m = ({56'd0, cw_q[7:0]} << 28) & SRC_MASK;

	logic gated, bypass;
	assign gated = cw_q[nvic_pkg::CW_SFTRST] | cw_q[nvic_pkg::CW_GATE];
	assign bypass = cw_q[nvic_pkg::CW_BYPASS];

	// highest level in service
	logic act_v;
	logic [1:0] act_l;
	always_comb begin
		act_v = 1'b0;
		act_l = 2'd0;
		for (int l = 0; l < 4; l++)
			if (owner_q[l] != 7'd0) begin
				act_v = 1'b1;
				act_l = 2'(l);
			end
	end

	// candidate search: level first, then source number
	logic in_delay;
	logic [63:0] cmask;
	logic [6:0] tb [4];
	logic cand_v;
	logic [5:0] cand;
	assign in_delay = (phase_q == nvic_pkg::PH_DELAY1) || (phase_q == nvic_pkg::PH_DELAY2);
	assign cmask = (in_delay ? held_q : live) & en_m & ~fiq_m;
	always_comb begin
		cand_v = 1'b0;
		cand = '0;
		for (int l = 0; l < 4; l++)
			tb[l] = nvic_pkg::top_bit(cmask & lvl_m[l]);
		for (int l = 3; l >= 0; l--) begin
			if (!cand_v && tb[l][6] &&
					!(act_v && (cw_q[nvic_pkg::CW_NONEST] || 2'(l) <= act_l))) begin
				cand_v = 1'b1;
				cand = tb[l][5:0];
			end
		end
	end

	logic [6:0] byp_tb;
	assign byp_tb = nvic_pkg::top_bit(live & ~fiq_m);

	// priority word read and write
	logic [3:0] pn;
	logic [31:0] prio_rd, prio_new;
	assign pn = 4'(base - nvic_pkg::R_PRIO0);
	assign prio_rd = {4'd0, settings_q[{pn, 2'd3}], 4'd0, settings_q[{pn, 2'd2}],
		4'd0, settings_q[{pn, 2'd1}], 4'd0, settings_q[{pn, 2'd0}]};
	assign prio_new = nvic_pkg::apply_op(prio_rd, wd_q, aop) & nvic_pkg::PRI_RW_MASK;

	// vector address and debug view
	logic [2:0] pf;
	logic [4:0] pitch;
	logic [31:0] vec_val, dbg_val;
	logic [63:0] dreq_src, dreq;
	logic [3:0] insvc, bylvl, lreq;
	logic fiq_pend;
	assign pf = cw_q[23:21];
	assign pitch = (pf <= 3'd1) ? 5'd4 : {pf, 2'b00};
	assign vec_val = vbase_q + {21'd0, 11'(cur_q) * 11'(pitch)};
	assign fiq_pend = |(live & fiq_m);
	assign dreq_src = bypass ? live : held_q;
	assign dreq = dreq_src & en_m & ~fiq_m;
	always_comb begin
		lreq = '0;
		for (int l = 0; l < 4; l++) begin
			insvc[l] = (owner_q[l] != 7'd0);
			bylvl[l] = |(dreq & lvl_m[l]);
		end
		if (phase_q == nvic_pkg::PH_PENDING || phase_q == nvic_pkg::PH_SERVICE)
			lreq[settings_q[cur_q][1:0]] = 1'b1;
		dbg_val = {insvc, lreq, bylvl, 2'b00,
			cw_q[nvic_pkg::CW_FIQ_FINAL] & fiq_pend,
			cw_q[nvic_pkg::CW_IRQ_FINAL] & waiting_q, 10'd0, phase_q};
	end

	logic [31:0] rd_val;
	always_comb begin
		rd_val = '0;
		if (aop == nvic_pkg::AOP_PLAIN) begin
			if (is_prio) rd_val = prio_rd;
			else begin
				case (base)
					nvic_pkg::R_VECTOR:  rd_val = vec_val;
					nvic_pkg::R_CTRL:    rd_val = cw_q;
					nvic_pkg::R_STAT:    rd_val = {26'd0, cur_q & nvic_pkg::STAT_MASK};
					nvic_pkg::R_RAW0:    rd_val = raw_q[31:0];
					nvic_pkg::R_RAW1:    rd_val = raw_q[63:32];
					nvic_pkg::R_VBASE:   rd_val = vbase_q;
					nvic_pkg::R_DEBUG:   rd_val = dbg_val;
					nvic_pkg::R_DBGRD0:  rd_val = nvic_pkg::DBGRD0_VAL;
					nvic_pkg::R_DBGRD1:  rd_val = nvic_pkg::DBGRD1_VAL;
					nvic_pkg::R_DFLAG:   rd_val = {16'd0, dflag_q};
					nvic_pkg::R_DREQ0:   rd_val = dreq_src[31:0];
					nvic_pkg::R_DREQ1:   rd_val = dreq_src[63:32];
					nvic_pkg::R_VERSION: rd_val = nvic_pkg::VERSION_VAL;
					default:             rd_val = '0;
				endcase
			end
		end
	end

	// which item kinds rerun the selection afterwards
	logic need_upd, enter_svc;
	always_comb begin
		need_upd = 1'b0;
		enter_svc = 1'b0;
		case (op_q)
			nvic_pkg::OP_READ: begin
				if (aop == nvic_pkg::AOP_PLAIN && !is_prio && base == nvic_pkg::R_VECTOR &&
						cw_q[nvic_pkg::CW_RSE]) begin
					need_upd = 1'b1;
					enter_svc = 1'b1;
				end
			end
			nvic_pkg::OP_WRITE: begin
				if (is_prio) need_upd = 1'b1;
				else begin
					case (base)
						nvic_pkg::R_VECTOR: begin
							need_upd = (aop == nvic_pkg::AOP_PLAIN);
							enter_svc = (aop == nvic_pkg::AOP_PLAIN);
						end
						nvic_pkg::R_LEVELACK: need_upd = (aop == nvic_pkg::AOP_PLAIN);
						nvic_pkg::R_CTRL, nvic_pkg::R_VBASE, nvic_pkg::R_DFLAG:
							need_upd = 1'b1;
						default: need_upd = 1'b0;
					endcase
				end
			end
			nvic_pkg::OP_LINE: need_upd = src_ok;
			default: need_upd = tick_fire;
		endcase
	end

	logic [31:0] cw_new, dflag_new;
	assign cw_new = nvic_pkg::apply_op(cw_q, wd_q, aop) & nvic_pkg::CW_RW_MASK;
	assign dflag_new = nvic_pkg::apply_op({16'd0, dflag_q}, wd_q, aop);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= nvic_pkg::op_t'(operation);
			off_q <= reg_offset;
			wd_q <= write_data;
			src_q <= source_number;
			lvl_q <= source_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= 1'b0;
			rd_q <= '0;
		end else if (cmd.exec) begin
			upd_q <= need_upd;
			rd_q <= (op_q == nvic_pkg::OP_READ) ? rd_val : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= nvic_pkg::CW_RESET;
			vbase_q <= '0;
			for (int i = 0; i < 64; i++) settings_q[i] <= '0;
			raw_q <= '0;
			held_q <= '0;
			for (int l = 0; l < 4; l++) owner_q[l] <= '0;
			cur_q <= '0;
			chosen_q <= '0;
			saved_q <= '0;
			waiting_q <= 1'b0;
			phase_q <= nvic_pkg::PH_IDLE;
			dflag_q <= '0;
			cnt_q <= '0;
		end else if (cmd.exec && tick_fire) begin
			// soft reset countdown expired
			cw_q <= nvic_pkg::CW_RESET;
			vbase_q <= '0;
			for (int i = 0; i < 64; i++) settings_q[i] <= '0;
			raw_q <= '0;
			held_q <= '0;
			for (int l = 0; l < 4; l++) owner_q[l] <= '0;
			cur_q <= '0;
			chosen_q <= '0;
			saved_q <= '0;
			waiting_q <= 1'b0;
			phase_q <= nvic_pkg::PH_IDLE;
			dflag_q <= '0;
			cnt_q <= '0;
		end else if (cmd.exec) begin
			if (enter_svc && waiting_q) begin
				owner_q[settings_q[cur_q][1:0]] <= {1'b0, cur_q} + 7'd1;
				waiting_q <= 1'b0;
			end
			case (op_q)
				nvic_pkg::OP_WRITE: begin
					if (is_prio) begin
						for (int k = 0; k < 4; k++)
							settings_q[{pn, 2'(k)}] <= ({1'b0, pn, 2'(k)} < 7'(NUM_SOURCES)) ?
								prio_new[k*8 +: 4] : 4'd0;
					end else if (aop == nvic_pkg::AOP_PLAIN && base == nvic_pkg::R_LEVELACK) begin
						for (int l = 0; l < 4; l++)
							if (wd_q[l]) owner_q[l] <= '0;
					end else if (base == nvic_pkg::R_CTRL) begin
						cw_q <= cw_new;
						if (!bypass && cw_new[nvic_pkg::CW_BYPASS]) waiting_q <= 1'b0;
						if (!cw_new[nvic_pkg::CW_SFTRST] || cw_new[nvic_pkg::CW_GATE])
							cnt_q <= '0;
						else if (!cw_q[nvic_pkg::CW_SFTRST])
							cnt_q <= 3'(SOFT_RESET_TICKS);
					end else if (base == nvic_pkg::R_VBASE) begin
						vbase_q <= nvic_pkg::apply_op(vbase_q, wd_q, aop) & nvic_pkg::VB_RW_MASK;
					end else if (base == nvic_pkg::R_DFLAG) begin
						dflag_q <= dflag_new[15:0] & nvic_pkg::DFLAG_MASK;
					end
				end
				nvic_pkg::OP_LINE: begin
					if (src_ok) raw_q[src_q] <= lvl_q;
				end
				nvic_pkg::OP_TICK: begin
					if (phase_q == nvic_pkg::PH_DELAY1) phase_q <= nvic_pkg::PH_DELAY2;
					else if (phase_q == nvic_pkg::PH_DELAY2) begin
						phase_q <= nvic_pkg::PH_PENDING;
						cur_q <= chosen_q;
						waiting_q <= 1'b1;
					end
					if (cnt_q != 3'd0) cnt_q <= cnt_q - 3'd1;
				end
				default: ;
			endcase
		end else if (cmd.update && upd_q) begin
			if (gated) begin
				phase_q <= nvic_pkg::PH_IDLE;
				chosen_q <= '0;
				saved_q <= '0;
				cur_q <= '0;
				waiting_q <= 1'b0;
				held_q <= '0;
			end else if (bypass) begin
				phase_q <= nvic_pkg::PH_IDLE;
				chosen_q <= '0;
				saved_q <= '0;
				waiting_q <= 1'b0;
				held_q <= live;
				cur_q <= byp_tb[6] ? byp_tb[5:0] : 6'd0;
			end else if (in_delay) begin
				if (cand_v) chosen_q <= cand;
				else begin
					phase_q <= act_v ? nvic_pkg::PH_SERVICE : nvic_pkg::PH_IDLE;
					cur_q <= act_v ? saved_q : 6'd0;
				end
			end else if (!waiting_q) begin
				held_q <= live;
				if (cand_v) begin
					saved_q <= cur_q;
					cur_q <= '0;
					chosen_q <= cand;
					phase_q <= nvic_pkg::PH_DELAY1;
				end else if (!act_v) begin
					phase_q <= nvic_pkg::PH_IDLE;
					cur_q <= '0;
				end else
					phase_q <= nvic_pkg::PH_SERVICE;
			end
		end
	end

	// result register
	assign sts.out_free = !out_valid_q || !out_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_data <= rd_q;
			irq_request <= !gated && cw_q[nvic_pkg::CW_IRQ_FINAL] && waiting_q;
			fiq_request <= !gated && cw_q[nvic_pkg::CW_FIQ_FINAL] && fiq_pend;
			busy_res <= !gated && |(live & (en_m | fiq_m));
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ sv/nested_vectored_interrupt_collector_core.sv @@
// Vectored priority interrupt collector, 64 sources, one item per transfer.
// After the capture edge the controller steps through execute, selection
// update and result load before the result is valid; a new item is taken
// only once the controller is back in idle. A stalled result holds the load step.
// arst_n clears the register and selection state and sets the control word to its gate/soft reset value.
`default_nettype none
module nested_vectored_interrupt_collector_core #(
	parameter int NUM_SOURCES      = 64,
	parameter int SOFT_RESET_TICKS = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	// item channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire [1:0]   operation,
	input  wire [12:0]  reg_offset,
	input  wire [31:0]  write_data,
	input  wire [5:0]   source_number,
	input  wire         source_level,
	// result channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] read_data,
	output logic        irq_request,
	output logic        fiq_request,
	output logic        busy_res
);

	// controller and datapath talk only through these
	nvic_pkg::cmd_t    cmd;
	nvic_pkg::status_t sts;

	nvic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// register file, priority select and the result register
	nvic_dp #(
		.NUM_SOURCES      (NUM_SOURCES),
		.SOFT_RESET_TICKS (SOFT_RESET_TICKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.reg_offset    (reg_offset),
		.write_data    (write_data),
		.source_number (source_number),
		.source_level  (source_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.irq_request   (irq_request),
		.fiq_request   (fiq_request),
		.busy_res      (busy_res)
	);

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for nested_vectored_interrupt_collector_core.
// A directed table and then random bus, line and tick items; every result is
// checked against an in-bench predictor or the value given in its row. Depends on nvic_pkg and the core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int RAND_ITEMS = 1650;
	localparam int QUIET_TAIL = 150;     // last items: no idling on either side
	localparam int CYCLE_LIMIT = 400000;
	localparam int RST_TICKS = 4;

	typedef struct packed {
		nvic_pkg::op_t op;
		logic [12:0] off;
		logic [31:0] data;
		logic [5:0]  src;
		logic        lvl;
	} item_t;

	typedef struct packed {
		logic [31:0] rd;
		logic        irq;
		logic        fiq;
		logic        busy;
	} outcome_t;

	typedef struct packed {
		item_t    it;
		logic     typed;    // expected outcome given in the row
		outcome_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = '0;
	logic [12:0] reg_offset = '0;
	logic [31:0] write_data = '0;
	logic [5:0]  source_number = '0;
	logic        source_level = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic        irq_request;
	logic        fiq_request;
	logic        busy_res;

	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	outcome_t pending_outcomes[$];

	always #5 clk = ~clk;

	nested_vectored_interrupt_collector_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .reg_offset(reg_offset), .write_data(write_data),
		.source_number(source_number), .source_level(source_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .irq_request(irq_request),
		.fiq_request(fiq_request), .busy_res(busy_res)
	);

	// ---------------------------------------------------------------
	// Collector predictor: shadow state of the block
	// ---------------------------------------------------------------
	logic [31:0] m_ctrl, m_vbase;
	logic [3:0]  m_cfg[64];         // {swtrig, enable, level[1:0]}
	logic [63:0] m_raw, m_held;
	logic [6:0]  m_owner[4];        // source+1 in service per level, 0 = free
	logic [5:0]  m_cur, m_chosen, m_saved;
	logic        m_waiting;
	nvic_pkg::phase_t m_phase;
	logic [15:0] m_dflag;
	int          m_countdown;

	function automatic logic [63:0] live_lines();
		logic [63:0] m;
		m = m_raw;
		for (int i = 0; i < 64; i++) if (m_cfg[i][3]) m[i] = 1'b1;
		return m;
	endfunction

	function automatic logic [63:0] enabled_lines();
		logic [63:0] m;
		for (int i = 0; i < 64; i++) m[i] = m_cfg[i][2];
		return m;
	endfunction

	function automatic logic [63:0] fiq_lines();
		return {28'd0, m_ctrl[7:0], 28'd0};
	endfunction

	function automatic logic [63:0] lines_at_level(int l);
		logic [63:0] m;
		for (int i = 0; i < 64; i++) m[i] = (m_cfg[i][1:0] == l[1:0]);
		return m;
	endfunction

	function automatic int highest(logic [63:0] m);
		for (int i = 63; i >= 0; i--) if (m[i]) return i;
		return -1;
	endfunction

	function automatic int serviced_level();
		for (int l = 3; l >= 0; l--) if (m_owner[l] != 0) return l;
		return -1;
	endfunction

	// best IRQ candidate that may preempt the level in service
	function automatic int pick_source(logic [63:0] req, int act);
		logic [63:0] c;
		int b;
		c = req & enabled_lines() & ~fiq_lines();
		for (int l = 3; l >= 0; l--) begin
			if (act >= 0 && (m_ctrl[nvic_pkg::CW_NONEST] || l <= act)) continue;
			b = highest(c & lines_at_level(l));
			if (b >= 0) return b;
		end
		return -1;
	endfunction

	function automatic void clear_model();
		m_ctrl = nvic_pkg::CW_RESET;
		m_vbase = '0;
		for (int i = 0; i < 64; i++) m_cfg[i] = '0;
		m_raw = '0;
		m_held = '0;
		for (int i = 0; i < 4; i++) m_owner[i] = '0;
		m_cur = '0;
		m_waiting = 1'b0;
		m_phase = nvic_pkg::PH_IDLE;
		m_chosen = '0;
		m_saved = '0;
		m_dflag = '0;
		m_countdown = 0;
	endfunction

	function automatic void reselect();
		logic [63:0] live;
		int act, c;
		live = live_lines();
		if (m_ctrl[nvic_pkg::CW_SFTRST] || m_ctrl[nvic_pkg::CW_GATE]) begin
			m_phase = nvic_pkg::PH_IDLE;
			m_chosen = '0; m_saved = '0; m_cur = '0;
			m_waiting = 1'b0; m_held = '0;
			return;
		end
		if (m_ctrl[nvic_pkg::CW_BYPASS]) begin
			c = highest(live & ~fiq_lines());
			m_phase = nvic_pkg::PH_IDLE;
			m_chosen = '0; m_saved = '0;
			m_waiting = 1'b0;
			m_held = live;
			m_cur = c >= 0 ? c[5:0] : 6'd0;
			return;
		end
		act = serviced_level();
		if (m_phase == nvic_pkg::PH_DELAY1 || m_phase == nvic_pkg::PH_DELAY2) begin
			c = pick_source(m_held, act);
			if (c >= 0) begin
				m_chosen = c[5:0];
				return;
			end
			m_phase = act >= 0 ? nvic_pkg::PH_SERVICE : nvic_pkg::PH_IDLE;
			m_cur = act >= 0 ? m_saved : 6'd0;
			return;
		end
		if (m_waiting) return;
		m_held = live;
		c = pick_source(m_held, act);
		if (c >= 0) begin
			m_saved = m_cur;
			m_cur = '0;
			m_chosen = c[5:0];
			m_phase = nvic_pkg::PH_DELAY1;
			return;
		end
		if (act < 0) begin
			m_phase = nvic_pkg::PH_IDLE;
			m_cur = '0;
		end else
			m_phase = nvic_pkg::PH_SERVICE;
	endfunction

	function automatic void take_vector();
		if (!m_waiting) return;
		m_owner[m_cfg[m_cur][1:0]] = {1'b0, m_cur} + 7'd1;
		m_waiting = 1'b0;
	endfunction

	function automatic logic [31:0] merge_alias(logic [31:0] old, logic [31:0] v,
		logic [1:0] a);
		case (nvic_pkg::aop_t'(a))
			nvic_pkg::AOP_SET: return old | v;
			nvic_pkg::AOP_CLR: return old & ~v;
			nvic_pkg::AOP_TOG: return old ^ v;
			default: return v;
		endcase
	endfunction

	function automatic logic [31:0] prio_word(int n);
		logic [31:0] v;
		v = '0;
		for (int k = 0; k < 4; k++) v[k*8 +: 4] = m_cfg[n*4 + k];
		return v;
	endfunction

	function automatic logic [63:0] request_view();
		return m_ctrl[nvic_pkg::CW_BYPASS] ? live_lines() : m_held;
	endfunction

	function automatic logic [31:0] debug_word();
		logic [63:0] req;
		logic [3:0]  insvc, bylvl, lreq;
		logic [31:0] v;
		req = request_view() & enabled_lines() & ~fiq_lines();
		insvc = '0; bylvl = '0; lreq = '0;
		for (int i = 0; i < 4; i++) insvc[i] = (m_owner[i] != 0);
		for (int i = 0; i < 64; i++) if (req[i]) bylvl[m_cfg[i][1:0]] = 1'b1;
		if (m_phase == nvic_pkg::PH_PENDING || m_phase == nvic_pkg::PH_SERVICE)
			lreq[m_cfg[m_cur][1:0]] = 1'b1;
		v = {insvc, lreq, bylvl, 14'd0, m_phase};
		if (m_ctrl[nvic_pkg::CW_FIQ_FINAL] && |(live_lines() & fiq_lines())) v[17] = 1'b1;
		if (m_ctrl[nvic_pkg::CW_IRQ_FINAL] && m_waiting) v[16] = 1'b1;
		return v;
	endfunction

	function automatic logic [31:0] bus_read(logic [12:0] off);
		logic [8:0]  idx;
		logic [31:0] v, pitch;
		logic [63:0] rq;
		idx = off[12:4];
		if (off[3:2] != nvic_pkg::AOP_PLAIN) return '0;
		if (idx >= nvic_pkg::R_PRIO0 && idx <= nvic_pkg::R_PRIO15)
			return prio_word(int'(idx - nvic_pkg::R_PRIO0));
		v = '0;
		rq = request_view();
		case (idx)
			nvic_pkg::R_VECTOR: begin
				pitch = m_ctrl[23:21] <= 1 ? 32'd4 : {27'd0, m_ctrl[23:21], 2'b00};
				v = m_vbase + m_cur * pitch;
				if (m_ctrl[nvic_pkg::CW_RSE]) begin
					take_vector();
					reselect();
				end
			end
			nvic_pkg::R_CTRL:    v = m_ctrl;
			nvic_pkg::R_STAT:    v = {26'd0, m_cur & nvic_pkg::STAT_MASK};
			nvic_pkg::R_RAW0:    v = m_raw[31:0];
			nvic_pkg::R_RAW1:    v = m_raw[63:32];
			nvic_pkg::R_VBASE:   v = m_vbase;
			nvic_pkg::R_DEBUG:   v = debug_word();
			nvic_pkg::R_DBGRD0:  v = nvic_pkg::DBGRD0_VAL;
			nvic_pkg::R_DBGRD1:  v = nvic_pkg::DBGRD1_VAL;
			nvic_pkg::R_DFLAG:   v = {16'd0, m_dflag};
			nvic_pkg::R_DREQ0:   v = rq[31:0];
			nvic_pkg::R_DREQ1:   v = rq[63:32];
			nvic_pkg::R_VERSION: v = nvic_pkg::VERSION_VAL;
			default:   v = '0;
		endcase
		return v;
	endfunction

	function automatic void bus_write(logic [12:0] off, logic [31:0] v);
		logic [8:0]  idx;
		logic [1:0]  a;
		logic [31:0] old, nw;
		int n;
		idx = off[12:4];
		a = off[3:2];
		if (idx >= nvic_pkg::R_PRIO0 && idx <= nvic_pkg::R_PRIO15) begin
			n = int'(idx - nvic_pkg::R_PRIO0);
			nw = merge_alias(prio_word(n), v, a) & nvic_pkg::PRI_RW_MASK;
			for (int k = 0; k < 4; k++) m_cfg[n*4 + k] = nw[k*8 +: 4];
			reselect();
			return;
		end
		case (idx)
			nvic_pkg::R_VECTOR: begin
				if (a != nvic_pkg::AOP_PLAIN) return;
				take_vector();
			end
			nvic_pkg::R_LEVELACK: begin
				if (a != nvic_pkg::AOP_PLAIN) return;
				for (int i = 0; i < 4; i++) if (v[i]) m_owner[i] = '0;
			end
			nvic_pkg::R_CTRL: begin
				old = m_ctrl;
				nw = merge_alias(old, v, a) & nvic_pkg::CW_RW_MASK;
				m_ctrl = nw;
				if (!old[nvic_pkg::CW_BYPASS] && nw[nvic_pkg::CW_BYPASS]) m_waiting = 1'b0;
				if (!nw[nvic_pkg::CW_SFTRST] || nw[nvic_pkg::CW_GATE]) m_countdown = 0;
				else if (!old[nvic_pkg::CW_SFTRST]) m_countdown = RST_TICKS;
			end
			nvic_pkg::R_VBASE: m_vbase = merge_alias(m_vbase, v, a) & nvic_pkg::VB_RW_MASK;
			nvic_pkg::R_DFLAG: begin
				nw = merge_alias({16'd0, m_dflag}, v, a);
				m_dflag = nw[15:0] & nvic_pkg::DFLAG_MASK;
			end
			default: return;
		endcase
		reselect();
	endfunction

	function automatic outcome_t collect(item_t it);
		outcome_t r;
		logic gated;
		r = '0;
		case (it.op)
			nvic_pkg::OP_READ:  r.rd = bus_read(it.off);
			nvic_pkg::OP_WRITE: bus_write(it.off, it.data);
			nvic_pkg::OP_LINE: begin
				m_raw[it.src] = it.lvl;
				reselect();
			end
			default: begin
				if (m_phase == nvic_pkg::PH_DELAY1)
					m_phase = nvic_pkg::PH_DELAY2;
				else if (m_phase == nvic_pkg::PH_DELAY2) begin
					m_phase = nvic_pkg::PH_PENDING;
					m_cur = m_chosen;
					m_waiting = 1'b1;
				end
				if (m_countdown != 0) begin
					m_countdown--;
					if (m_countdown == 0) begin
						clear_model();
						reselect();
					end
				end
			end
		endcase
		gated = m_ctrl[nvic_pkg::CW_SFTRST] | m_ctrl[nvic_pkg::CW_GATE];
		r.irq = !gated && m_ctrl[nvic_pkg::CW_IRQ_FINAL] && m_waiting;
		r.fiq = !gated && m_ctrl[nvic_pkg::CW_FIQ_FINAL] && |(live_lines() & fiq_lines());
		r.busy = !gated && |(live_lines() & (enabled_lines() | fiq_lines()));
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic item_t mk(nvic_pkg::op_t op, logic [8:0] idx, logic [1:0] a,
		logic [31:0] d, logic [5:0] s, logic l);
		item_t it;
		it.op = op; it.off = {idx, a, 2'b00}; it.data = d; it.src = s; it.lvl = l;
		return it;
	endfunction

	// mostly well-formed traffic: ungated setup, lines, ticks, service and ack
	function automatic item_t random_item();
		item_t it;
		int pick;
		logic [31:0] d;
		pick = $urandom_range(0, 99);
		d = $urandom;
		if (pick < 25)
			it = mk(nvic_pkg::OP_TICK, 9'(0), nvic_pkg::AOP_PLAIN, d, 6'($urandom),
				1'($urandom));
		else if (pick < 45)
			it = mk(nvic_pkg::OP_LINE, 9'(0), nvic_pkg::AOP_PLAIN, d, 6'($urandom),
				1'($urandom));
		else if (pick < 55)
			it = mk(nvic_pkg::OP_READ, nvic_pkg::R_VECTOR, nvic_pkg::AOP_PLAIN, d, '0, 1'b0);
		else if (pick < 62)
			it = mk(nvic_pkg::OP_WRITE, nvic_pkg::R_LEVELACK, nvic_pkg::AOP_PLAIN, d, '0,
				1'b0);
		else if (pick < 72)
			it = mk(nvic_pkg::OP_WRITE, 9'(nvic_pkg::R_PRIO0 + $urandom_range(0, 15)),
				2'($urandom), d, '0, 1'b0);
		else if (pick < 78) begin
			// keep the block ungated most of the time
			if ($urandom_range(0, 9) != 0) d[31:30] = 2'b00;
			it = mk(nvic_pkg::OP_WRITE, nvic_pkg::R_CTRL,
				$urandom_range(0, 3) == 0 ? 2'($urandom) : nvic_pkg::AOP_PLAIN,
				d, '0, 1'b0);
		end else if (pick < 88)
			it = mk(nvic_pkg::OP_READ, 9'($urandom_range(0, 31)), $urandom_range(0, 3) == 0 ?
				2'($urandom) : nvic_pkg::AOP_PLAIN, d, '0, 1'b0);
		else if (pick < 94)
			it = mk(nvic_pkg::OP_WRITE, $urandom_range(0, 2) == 0 ? nvic_pkg::R_VECTOR :
				($urandom_range(0, 1) ? nvic_pkg::R_VBASE : nvic_pkg::R_DFLAG),
				2'($urandom), d, '0, 1'b0);
		else
			it = mk(nvic_pkg::op_t'($urandom_range(0, 3)), '0, nvic_pkg::AOP_PLAIN, d,
				6'($urandom), 1'($urandom));
		// low byte-select bits are don't-care; the noise case covers the full offset range
		it.off[1:0] = 2'($urandom);
		if (pick >= 94) it.off = 13'($urandom);
		return it;
	endfunction

	function automatic row_t pred_row(item_t it);
		row_t r;
		r.it = it; r.typed = 1'b0; r.want = '0;
		return r;
	endfunction

	function automatic row_t typed_row(item_t it, logic [31:0] rd);
		row_t r;
		r.it = it; r.typed = 1'b1; r.want = '0;
		r.want.rd = rd;
		return r;
	endfunction

	row_t directed[$];

	// one transfer on the item channel; valid may stay high for a follow-on item
	task automatic send(row_t r, bit last_in_run);
		outcome_t got;
		@(negedge clk);
		operation <= r.it.op;
		reg_offset <= r.it.off;
		write_data <= r.it.data;
		source_number <= r.it.src;
		source_level <= r.it.lvl;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = collect(r.it);
		pending_outcomes.push_back(r.typed ? r.want : got);
		if (last_in_run || (!quiet && $urandom_range(0, 5) == 0)) begin
			@(negedge clk);
			in_valid <= 1'b0;
			if (!last_in_run) repeat ($urandom_range(0, 4)) @(negedge clk);
		end
	endtask

	initial begin
		clear_model();
		// reset value, constant registers, alias and unknown reads
		directed.push_back(typed_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_CTRL,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0), nvic_pkg::CW_RESET));
		directed.push_back(typed_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_VERSION,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0), nvic_pkg::VERSION_VAL));
		directed.push_back(typed_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_DBGRD0,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0), nvic_pkg::DBGRD0_VAL));
		directed.push_back(typed_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_DBGRD1,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0), nvic_pkg::DBGRD1_VAL));
		directed.push_back(typed_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_CTRL,
			nvic_pkg::AOP_SET, '0, '0, 1'b0), 32'd0));
		directed.push_back(typed_row({nvic_pkg::OP_READ, 13'h1FFF, 32'd0, 6'd0, 1'b0},
			32'd0));
		// ungate, program two priority words, raise top source
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_CTRL,
			nvic_pkg::AOP_PLAIN, 32'h0003_0000, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_PRIO0,
			nvic_pkg::AOP_PLAIN, 32'hFFFF_FFFF, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_PRIO15,
			nvic_pkg::AOP_PLAIN, 32'h0705_0604, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_LINE, '0, nvic_pkg::AOP_PLAIN, '0,
			6'd63, 1'b1)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_TICK, '0, nvic_pkg::AOP_PLAIN, '0, '0,
			1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_TICK, '0, nvic_pkg::AOP_PLAIN, '0, '0,
			1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_VBASE,
			nvic_pkg::AOP_PLAIN, 32'hFFFF_FFFF, '0, 1'b0)));
		// pitch 7 and read-side service entry via set alias
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_CTRL,
			nvic_pkg::AOP_SET, 32'h00E4_0000, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_VECTOR,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_DEBUG,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_VECTOR,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_LEVELACK,
			nvic_pkg::AOP_PLAIN, 32'hF, '0, 1'b0)));
		// bypass with full FIQ routing, then a routed line
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_CTRL,
			nvic_pkg::AOP_PLAIN, 32'h0013_00FF, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_LINE, '0, nvic_pkg::AOP_PLAIN, '0,
			6'd30, 1'b1)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_DREQ0,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_DREQ1,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_DFLAG,
			nvic_pkg::AOP_TOG, 32'hFFFF_FFFF, '0, 1'b0)));
		// soft reset: arm, then count down
		directed.push_back(pred_row(mk(nvic_pkg::OP_WRITE, nvic_pkg::R_CTRL,
			nvic_pkg::AOP_PLAIN, 32'h8000_0000, '0, 1'b0)));
		for (int i = 0; i < RST_TICKS; i++)
			directed.push_back(pred_row(mk(nvic_pkg::OP_TICK, '0, nvic_pkg::AOP_PLAIN, '0,
				'0, 1'b0)));
		directed.push_back(pred_row(mk(nvic_pkg::OP_READ, nvic_pkg::R_DFLAG,
			nvic_pkg::AOP_PLAIN, '0, '0, 1'b0)));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) send(directed[i], 1'b0);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
			send(pred_row(random_item()), n == RAND_ITEMS - 1);
		end

		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("nested_vectored_interrupt_collector_core: match");
		else
			$display("nested_vectored_interrupt_collector_core: mismatch");
		$finish;
	end

	// result side back-pressure in short bursts
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("result %s: got %h, expected %h", field, got, want);
		errors++;
	endtask

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		outcome_t w;
		if (out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0)
				report("unexpected", read_data, '0);
			else begin
				w = pending_outcomes.pop_front();
				if (read_data !== w.rd) report("read_data", read_data, w.rd);
				if (irq_request !== w.irq) report("irq_request", {31'd0, irq_request},
					{31'd0, w.irq});
				if (fiq_request !== w.fiq) report("fiq_request", {31'd0, fiq_request},
					{31'd0, w.fiq});
				if (busy_res !== w.busy) report("busy_res", {31'd0, busy_res},
					{31'd0, w.busy});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("nested_vectored_interrupt_collector_core: mismatch");
			$finish;
		end
	end
endmodule
`default_nettype wire
